// ===== hdl/fts_pkg.sv =====
// ============================================================================
// fts_pkg: shared types and constants for the frame time window statistics
// Field widths, scaling constants, channel word layouts and sequencer codes.
// ============================================================================
package fts_pkg;

    localparam int US_W       = 31;
    localparam int MS_W       = 22;
    localparam int RATE_W     = 17;
    localparam int US_PER_MS  = 1000;
    localparam int RATE_SCALE = 100000;

    // Reciprocal of US_PER_MS, ceil(2**MS_SHIFT / 1000). The product with any
    // 31-bit time, shifted right by MS_SHIFT, is the truncated quotient.
    localparam int          MS_SHIFT = 41;
    localparam logic [31:0] MS_RECIP = 32'd2199023256;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int RECENT_FRAMES_DEF = 10;

    typedef struct packed {
        logic [US_W-1:0] elapsed_us;
    } t_in_word;

    typedef struct packed {
        logic [RATE_W-1:0] rate_recent;
        logic [RATE_W-1:0] rate_min;
        logic [RATE_W-1:0] rate_avg;
        logic [RATE_W-1:0] rate_max;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CONV,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIV_RECENT,
        DIV_MIN,
        DIV_AVG,
        DIV_MAX
    } t_div_sel;

endpackage

// ===== hdl/fts_in_if.sv =====
// ============================================================================
// fts_in_if: input channel carrying one frame time word
// Valid/ready handshake with the elapsed microseconds as payload.
// ============================================================================
interface fts_in_if;
    import fts_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fts_out_if.sv =====
// ============================================================================
// fts_out_if: output channel carrying one word of four frame rates
// Valid/ready handshake with the rate word as payload.
// ============================================================================
interface fts_out_if;
    import fts_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fts_ram.sv =====
// ============================================================================
// fts_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module fts_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/fts_div.sv =====
// ============================================================================
// fts_div: serial restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is valid.
// ============================================================================
module fts_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 28
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // The remainder stays below the divisor, so the shifted value fits one extra bit.
    always_comb begin
        w_sh   = {r_rem, r_num[NUM_W-1]};
        w_ge   = (w_sh >= {1'b0, r_den});
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

// ===== hdl/frame_time_window_stats.sv =====
// ============================================================================
// frame_time_window_stats: sliding window frame rate statistics
// Keeps a ring of frame times in milliseconds and reports recent, average,
// minimum and maximum frame rates in hundredths of frames per second.
// ============================================================================
//
//  Channel   Dir  Word        Contents
//  i_frame   in   t_in_word   elapsed_us: microseconds since the last frame
//  o_rates   out  t_out_word  rate_recent, rate_min, rate_avg, rate_max
//
// The time from acceptance until i_frame.ready rises again is set by the
// single serial divider, used four times for the rates, and by the single
// read port of the ring RAM during the scan; the millisecond conversion is
// one combinational reciprocal multiplication. After reset the block writes
// ones into every ring slot and holds i_frame.ready low until that pass is
// over. A result that is not taken waits in the output register; the next
// frame word is accepted meanwhile and its result holds in the sequencer
// until that register is free.
//
module frame_time_window_stats #(
    parameter int HISTORY_DEPTH = fts_pkg::HISTORY_DEPTH_DEF,
    parameter int RECENT_FRAMES = fts_pkg::RECENT_FRAMES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fts_in_if.sink    i_frame,
    fts_out_if.source o_rates
);
    import fts_pkg::*;

    // Ring address, scan counter and accumulator widths.
    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + RECENT_FRAMES);
    localparam int TOT_W  = AW + MS_W;
    localparam int RSUM_W = $clog2(RECENT_FRAMES + 1) + MS_W;
    localparam int DEN_W  = (TOT_W > RSUM_W) ? TOT_W : RSUM_W;
    localparam int CNT_MX = (HISTORY_DEPTH > RECENT_FRAMES) ? HISTORY_DEPTH : RECENT_FRAMES;
    localparam int NUM_W  = $clog2(CNT_MX * RATE_SCALE + 1);
    localparam int PROD_W = US_W + $bits(MS_RECIP);

    localparam logic [AW-1:0] LAST_SLOT     = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] SCAN_TOT      = CW'(HISTORY_DEPTH);
    localparam logic [CW-1:0] SCAN_TOT_LAST = CW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] SCAN_LAST     = CW'(HISTORY_DEPTH + RECENT_FRAMES - 1);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [MS_W-1:0]   r_ms, n_ms;
    logic [US_W-1:0]   r_us;
    t_div_sel          r_sel, n_sel;
    logic              r_div_wait, n_div_wait;
    logic              r_rd_vld;
    logic              r_rd_tot;
    logic [TOT_W-1:0]  r_total;
    logic [RSUM_W-1:0] r_recent;
    logic [MS_W-1:0]   r_lo;
    logic [MS_W-1:0]   r_hi;
    t_out_word         r_res;
    t_out_word         r_out;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_rd_issue;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [MS_W-1:0]   w_ram_wdata;
    logic [MS_W-1:0]   w_ram_rdata;
    logic              w_div_start;
    logic [NUM_W-1:0]  w_div_num;
    logic [DEN_W-1:0]  w_div_den;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_div_quo;
    logic [PROD_W-1:0] w_ms_prod;
    logic [MS_W-1:0]   w_ms_quo;

    fts_ram #(
        .WIDTH (MS_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    fts_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign i_frame.ready = (r_state == S_IDLE);
    assign w_accept      = i_frame.valid && (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || o_rates.ready;
    assign o_rates.valid = r_out_valid;
    assign o_rates.data  = r_out;

    // Whole milliseconds of the held frame time by reciprocal multiplication;
    // the upper product bits are the truncated quotient by 1000.
    assign w_ms_prod = r_us * MS_RECIP;
    assign w_ms_quo  = w_ms_prod[MS_SHIFT +: MS_W];

    // Divider operands for the rate selected by the sequencer. Every divisor
    // is at least its count.
    always_comb begin
        case (r_sel)
            DIV_RECENT: begin
                w_div_num = NUM_W'(RECENT_FRAMES * RATE_SCALE);
                w_div_den = DEN_W'(r_recent);
            end
            DIV_MIN: begin
                w_div_num = NUM_W'(RATE_SCALE);
                w_div_den = DEN_W'(r_hi);
            end
            DIV_AVG: begin
                w_div_num = NUM_W'(HISTORY_DEPTH * RATE_SCALE);
                w_div_den = DEN_W'(r_total);
            end
            DIV_MAX: begin
                w_div_num = NUM_W'(RATE_SCALE);
                w_div_den = DEN_W'(r_lo);
            end
            default: begin
                w_div_num = NUM_W'(RATE_SCALE);
                w_div_den = DEN_W'(r_lo);
            end
        endcase
    end

    // Sequencer. The scan first reads the whole ring in address order for the
    // total, minimum and maximum, then walks backward from the newest slot for
    // the recent window, so a window longer than the ring wraps as it should.
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_ms        = r_ms;
        n_sel       = r_sel;
        n_div_wait  = r_div_wait;
        w_rd_issue  = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_slot;
        w_ram_wdata = r_ms;
        w_div_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_addr;
                w_ram_wdata = MS_W'(1);
                if (r_addr == LAST_SLOT) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                // Frames shorter than one millisecond count as one.
                if (w_ms_quo == '0) begin
                    n_ms = MS_W'(1);
                end else begin
                    n_ms = w_ms_quo;
                end
                n_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                w_ram_we = 1'b1;
                n_addr   = '0;
                n_cnt    = '0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                w_rd_issue = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == SCAN_TOT_LAST) begin
                    n_addr = r_slot;
                end else if (r_cnt < SCAN_TOT_LAST) begin
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_addr = (r_addr == '0) ? LAST_SLOT : r_addr - 1'b1;
                end
                if (r_cnt == SCAN_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_sel      = DIV_RECENT;
                n_div_wait = 1'b0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (!r_div_wait) begin
                    w_div_start = 1'b1;
                    n_div_wait  = 1'b1;
                end else if (w_div_done) begin
                    n_div_wait = 1'b0;
                    case (r_sel)
                        DIV_RECENT: n_sel = DIV_MIN;
                        DIV_MIN:    n_sel = DIV_AVG;
                        DIV_AVG:    n_sel = DIV_MAX;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_sel       <= DIV_RECENT;
            r_div_wait  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_slot     <= n_slot;
            r_cnt      <= n_cnt;
            r_sel      <= n_sel;
            r_div_wait <= n_div_wait;
            r_rd_vld   <= w_rd_issue;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rates.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Accumulators take the registered read data in the cycle after each scan read.
    always_ff @(posedge i_clk) begin
        r_ms     <= n_ms;
        r_rd_tot <= (r_cnt < SCAN_TOT);
        if (w_accept) begin
            r_us <= i_frame.data.elapsed_us;
        end
        if (r_state == S_WRITE) begin
            r_total  <= '0;
            r_recent <= '0;
            r_lo     <= '1;
            r_hi     <= '0;
        end else if (r_rd_vld) begin
            if (r_rd_tot) begin
                r_total <= r_total + TOT_W'(w_ram_rdata);
                if (w_ram_rdata < r_lo) begin
                    r_lo <= w_ram_rdata;
                end
                if (w_ram_rdata > r_hi) begin
                    r_hi <= w_ram_rdata;
                end
            end else begin
                r_recent <= r_recent + RSUM_W'(w_ram_rdata);
            end
        end
        if ((r_state == S_DIV) && r_div_wait && w_div_done) begin
            case (r_sel)
                DIV_RECENT: r_res.rate_recent <= w_div_quo[RATE_W-1:0];
                DIV_MIN:    r_res.rate_min    <= w_div_quo[RATE_W-1:0];
                DIV_AVG:    r_res.rate_avg    <= w_div_quo[RATE_W-1:0];
                default:    r_res.rate_max    <= w_div_quo[RATE_W-1:0];
            endcase
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    // An accepted word always starts the millisecond conversion.
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV))
        else $error("accepted frame word did not enter conversion");

    // Every ring entry is at least one, so the total covers the depth.
    a_total_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_total >= TOT_W'(HISTORY_DEPTH)))
        else $error("ring total below depth after scan");

    // The scan must leave the shortest frame nonzero and no longer than the longest.
    a_lo_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_lo <= r_hi) && (r_lo != '0))
        else $error("minimum and maximum frame times out of order");

    // The divider only reports while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == S_DIV) && r_div_wait))
        else $error("divider finished outside a division step");

endmodule
